// File: rtl/lst_pkg.sv
`timescale 1ns / 1ps
// Lane segment tracker package: action and steer codes, register indexes,
// reset values, queue flag struct and frame snapshot slot numbers.
// No dependencies.
package lst_pkg;

  typedef enum logic [1:0] {
    ACT_SEG       = 2'd0,
    ACT_SEG_CLOSE = 2'd1,
    ACT_CLOSE     = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_t;

  localparam logic [1:0] REG_CENTRE   = 2'd0;
  localparam logic [1:0] REG_MARGIN   = 2'd1;
  localparam logic [1:0] REG_DEADZONE = 2'd2;

  localparam int CENTRE_W   = 10;
  localparam int MARGIN_W   = 8;
  localparam int DEADZONE_W = 9;
  localparam int CFG_W      = 10;

  localparam logic [CENTRE_W-1:0]   CENTRE_RESET   = 10'd320;
  localparam logic [MARGIN_W-1:0]   MARGIN_RESET   = 8'd10;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 9'd35;

  localparam int RESET_NONE = -1;
  localparam int RESET_FAR  = 1000;

  // slots of the frame snapshot handed from the back end to the result pipe
  localparam int SNAP_LSX   = 0;
  localparam int SNAP_LSY   = 1;
  localparam int SNAP_LEX   = 2;
  localparam int SNAP_LEY   = 3;
  localparam int SNAP_RSX   = 4;
  localparam int SNAP_RSY   = 5;
  localparam int SNAP_REX   = 6;
  localparam int SNAP_REY   = 7;
  localparam int SNAP_SLOTS = 8;

  typedef struct packed {
    logic take;
    logic close;
  } work_t;

endpackage

// File: rtl/lst_front.sv
`timescale 1ns / 1ps
// Front end: decodes the action, orients the segment (lower end first) and
// pushes useful words into the queue. Depends on lst_pkg.
module lst_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [COORD_BITS-1:0] first_x,
  input  logic [COORD_BITS-1:0] first_y,
  input  logic [COORD_BITS-1:0] second_x,
  input  logic [COORD_BITS-1:0] second_y,
  input  logic                  q_ready,
  output logic                  push,
  output lst_pkg::work_t        work,
  output logic [COORD_BITS-1:0] sx,
  output logic [COORD_BITS-1:0] sy,
  output logic [COORD_BITS-1:0] ex,
  output logic [COORD_BITS-1:0] ey
);
  import lst_pkg::*;

  always_comb begin
    work = '0;
    unique case (action_t'(action))
      ACT_SEG:       work.take = 1'b1;
      ACT_SEG_CLOSE: begin
        work.take  = 1'b1;
        work.close = 1'b1;
      end
      ACT_CLOSE:     work.close = 1'b1;
      default:       work = '0;
    endcase
  end

  // on equal y the second endpoint is the start
  always_comb begin
    if (first_y > second_y) begin
      sx = first_x;
      sy = first_y;
      ex = second_x;
      ey = second_y;
    end else begin
      sx = second_x;
      sy = second_y;
      ex = first_x;
      ey = first_y;
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && (work.take || work.close);

endmodule

// File: rtl/lst_queue.sv
`timescale 1ns / 1ps
// Two-entry word queue between front and back end.
// Depends on lst_pkg only through the instantiating module.
module lst_queue #(
  parameter int WIDTH = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

// File: rtl/lst_back.sv
`timescale 1ns / 1ps
// Back end: holds the frame registers, applies segments, and on a frame
// close hands a snapshot to the result pipe and reloads. Depends on lst_pkg.
module lst_back #(
  parameter int COORD_BITS = 10,
  parameter int SW         = COORD_BITS + 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lst_pkg::CENTRE_W-1:0]   centre,
  input  logic [lst_pkg::MARGIN_W-1:0]   margin,
  input  logic                           q_valid,
  input  lst_pkg::work_t                 work,
  input  logic [COORD_BITS-1:0]          sx_in,
  input  logic [COORD_BITS-1:0]          sy_in,
  input  logic [COORD_BITS-1:0]          ex_in,
  input  logic [COORD_BITS-1:0]          ey_in,
  output logic                           pop,
  output logic                           snap_valid,
  output logic signed [SW-1:0]           snap [lst_pkg::SNAP_SLOTS],
  input  logic                           snap_ready
);
  import lst_pkg::*;

  logic signed [SW-1:0] lsx, lsy, lex, ley, rsx, rsy, rex, rey;
  logic signed [SW-1:0] lsx_next, lsy_next, lex_next, ley_next;
  logic signed [SW-1:0] rsx_next, rsy_next, rex_next, rey_next;
  logic signed [SW-1:0] sx, sy, ex, ey, c, m;
  logic                 left_start, left_end;
  logic                 slot_free;

  assign sx = $signed(SW'(sx_in));
  assign sy = $signed(SW'(sy_in));
  assign ex = $signed(SW'(ex_in));
  assign ey = $signed(SW'(ey_in));
  assign c  = $signed(SW'(centre));
  assign m  = $signed(SW'(margin));

  always_comb begin
    lsx_next = lsx; lsy_next = lsy; lex_next = lex; ley_next = ley;
    rsx_next = rsx; rsy_next = rsy; rex_next = rex; rey_next = rey;
    left_start = (sx < c) && (sy > lsy);
    left_end   = (ex < rex - m) && (ey < ley);
    if (work.take) begin
      if (left_start) begin
        lsx_next = sx;
        lsy_next = sy;
      end else if ((sx > c) && (sy > rsy)) begin
        rsx_next = sx;
        rsy_next = sy;
      end
      if (left_end) begin
        lex_next = ex;
        ley_next = ey;
      end else if ((ex > lex + m) && (ey < rey)) begin
        rex_next = ex;
        rey_next = ey;
      end
    end
  end

  assign slot_free = !snap_valid || snap_ready;
  assign pop       = q_valid && (!work.close || slot_free);

  always_ff @(posedge clk) begin
    if (rst || (pop && work.close)) begin
      lsx <= SW'(RESET_NONE);
      lsy <= SW'(RESET_NONE);
      lex <= SW'(RESET_NONE);
      ley <= SW'(RESET_FAR);
      rsx <= SW'(RESET_NONE);
      rsy <= SW'(RESET_NONE);
      rex <= SW'(RESET_FAR);
      rey <= SW'(RESET_FAR);
    end else if (pop) begin
      lsx <= lsx_next; lsy <= lsy_next; lex <= lex_next; ley <= ley_next;
      rsx <= rsx_next; rsy <= rsy_next; rex <= rex_next; rey <= rey_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (pop && work.close) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && work.close) begin
      snap[SNAP_LSX] <= lsx_next;
      snap[SNAP_LSY] <= lsy_next;
      snap[SNAP_LEX] <= lex_next;
      snap[SNAP_LEY] <= ley_next;
      snap[SNAP_RSX] <= rsx_next;
      snap[SNAP_RSY] <= rsy_next;
      snap[SNAP_REX] <= rex_next;
      snap[SNAP_REY] <= rey_next;
    end
  end

endmodule

// File: rtl/lst_result.sv
`timescale 1ns / 1ps
// Result pipe: midpoints, track point, steer code and output register.
// Depends on lst_pkg.
module lst_result #(
  parameter int COORD_BITS = 10,
  parameter int SW         = COORD_BITS + 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lst_pkg::CENTRE_W-1:0]     centre,
  input  logic [lst_pkg::DEADZONE_W-1:0]   deadzone,
  input  logic                             snap_valid,
  input  logic signed [SW-1:0]             snap [lst_pkg::SNAP_SLOTS],
  output logic                             snap_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COORD_BITS:0]       track_x,
  output logic signed [COORD_BITS:0]       track_y,
  output logic                             both_found,
  output logic [1:0]                       steer_code
);
  import lst_pkg::*;

  // halves a sum, truncating toward zero
  function automatic logic signed [SW-1:0] half_sum(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    begin
      s = {a[SW-1], a} + {b[SW-1], b};
      s = s + {{SW{1'b0}}, s[SW]};
      half_sum = SW'(s >>> 1);
    end
  endfunction

  logic                 b_v, b_found, b_ready;
  logic signed [SW-1:0] msx, msy, mex, mey;
  logic                 c_v, c_found, c_ready;
  logic signed [SW-1:0] tx, ty;
  logic                 o_ready;
  logic signed [SW-1:0] cs, hi_lim, lo_lim;
  steer_t               steer;
  logic                 left_ok, right_ok;

  assign o_ready    = !out_valid || out_ready;
  assign c_ready    = !c_v || o_ready;
  assign b_ready    = !b_v || c_ready;
  assign snap_ready = b_ready;

  assign left_ok  = (snap[SNAP_LSX] != SW'(RESET_NONE)) && (snap[SNAP_LSY] != SW'(RESET_NONE));
  assign right_ok = (snap[SNAP_RSX] != SW'(RESET_NONE)) && (snap[SNAP_RSY] != SW'(RESET_NONE));

  assign cs     = $signed(SW'(centre));
  assign hi_lim = cs + $signed(SW'(deadzone));
  assign lo_lim = cs - $signed(SW'(deadzone));

  always_comb begin
    if (tx > hi_lim) begin
      steer = STEER_RIGHT;
    end else if (tx < lo_lim) begin
      steer = STEER_LEFT;
    end else begin
      steer = STEER_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_ready) b_v <= snap_valid;
      if (c_ready) c_v <= b_v;
      if (o_ready) out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && snap_valid) begin
      msx     <= half_sum(snap[SNAP_RSX], snap[SNAP_LSX]);
      msy     <= half_sum(snap[SNAP_RSY], snap[SNAP_LSY]);
      mex     <= half_sum(snap[SNAP_REX], snap[SNAP_LEX]);
      mey     <= half_sum(snap[SNAP_REY], snap[SNAP_LEY]);
      b_found <= left_ok && right_ok;
    end
    if (c_ready && b_v) begin
      c_found <= b_found;
      if (b_found) begin
        tx <= half_sum(msx, mex);
        ty <= half_sum(msy, mey);
      end else begin
        tx <= cs;
        ty <= '0;
      end
    end
    if (o_ready && c_v) begin
      track_x    <= (COORD_BITS + 1)'(tx);
      track_y    <= (COORD_BITS + 1)'(ty);
      both_found <= c_found;
      steer_code <= steer;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(track_x) && $stable(steer_code)))
    else $error("result changed while stalled");
  a_default_point: assert property (@(posedge clk) disable iff (rst)
    (c_v && !c_found) |-> (tx == cs && ty == '0))
    else $error("default track point wrong");
  a_found_y: assert property (@(posedge clk) disable iff (rst)
    (c_v && c_found) |-> (ty >= 0))
    else $error("track y negative with both lines found");

endmodule

// File: rtl/lane_segment_tracker.sv
`timescale 1ns / 1ps
// Lane segment tracker top level: stream ports, configuration registers,
// front end, word queue, back end and result pipe. Depends on lst_pkg.
//
// Use: one segment word per s_ word; s_tuser carries the action (segment,
// segment closing the frame, close only; code 3 is accepted and dropped).
// Each frame close gives one m_ word with the track point, a both-found flag
// and a steer code; the frame registers then reload for the next frame.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
// block is idle; indexes above 2 are ignored.
// Throughput: one word per cycle while m_tready keeps the result pipe
// draining. A closing word passes the queue, frame update, midpoint and
// track stages, then the output register with steer compare.
// Reset clears the queue and pipe, reloads the frame registers and sets the
// configuration to centre 320, margin 10, deadzone 35.
// When m_tready is low the result pipe fills, then the back end stops taking
// closing words, the two-word queue fills and s_tready drops.
module lane_segment_tracker #(
  parameter int COORD_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // first_x, first_y, second_x, second_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // action
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // track_x, track_y, both_found, steer_code, zero pad
  output logic [((2*COORD_BITS+6+7)/8)*8-1:0]    m_tdata,
  input  logic                                   cfg_wr_en,
  input  logic [1:0]                             cfg_index,
  input  logic [lst_pkg::CFG_W-1:0]              cfg_wdata
);
  import lst_pkg::*;

  localparam int SW     = COORD_BITS + 3;
  localparam int QW     = 2 + 4 * COORD_BITS;
  localparam int OUT_W  = ((2 * COORD_BITS + 6 + 7) / 8) * 8;

  logic [CENTRE_W-1:0]   centre;
  logic [MARGIN_W-1:0]   margin;
  logic [DEADZONE_W-1:0] deadzone;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre   <= CENTRE_RESET;
      margin   <= MARGIN_RESET;
      deadzone <= DEADZONE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTRE:   centre   <= cfg_wdata[CENTRE_W-1:0];
        REG_MARGIN:   margin   <= cfg_wdata[MARGIN_W-1:0];
        REG_DEADZONE: deadzone <= cfg_wdata[DEADZONE_W-1:0];
        default:      ;
      endcase
    end
  end

  logic                  q_ready, push, q_valid, pop;
  work_t                 f_work, b_work;
  logic [COORD_BITS-1:0] f_sx, f_sy, f_ex, f_ey;
  logic [COORD_BITS-1:0] b_sx, b_sy, b_ex, b_ey;
  logic [QW-1:0]         q_head;

  lst_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .action   (s_tuser),
    .first_x  (s_tdata[COORD_BITS-1:0]),
    .first_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .second_x (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .second_y (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .q_ready  (q_ready),
    .push     (push),
    .work     (f_work),
    .sx       (f_sx),
    .sy       (f_sy),
    .ex       (f_ex),
    .ey       (f_ey)
  );

  lst_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_work, f_sx, f_sy, f_ex, f_ey}),
    .ready     (q_ready),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign {b_work, b_sx, b_sy, b_ex, b_ey} = q_head;

  logic                 snap_valid, snap_ready;
  logic signed [SW-1:0] snap [SNAP_SLOTS];

  lst_back #(.COORD_BITS(COORD_BITS), .SW(SW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .centre     (centre),
    .margin     (margin),
    .q_valid    (q_valid),
    .work       (b_work),
    .sx_in      (b_sx),
    .sy_in      (b_sy),
    .ex_in      (b_ex),
    .ey_in      (b_ey),
    .pop        (pop),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  logic signed [COORD_BITS:0] track_x, track_y;
  logic                       both_found;
  logic [1:0]                 steer_code;

  lst_result #(.COORD_BITS(COORD_BITS), .SW(SW)) u_result (
    .clk        (clk),
    .rst        (rst),
    .centre     (centre),
    .deadzone   (deadzone),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .track_x    (track_x),
    .track_y    (track_y),
    .both_found (both_found),
    .steer_code (steer_code)
  );

  assign m_tdata = OUT_W'({steer_code, both_found, track_y, track_x});

endmodule
